// ===== design/lr_pkg.sv =====
// Shared types, constants and helpers for the line rasterizer.
package lr_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 16;
  localparam int ERR_W = COORD_W + 2;
  localparam int TILE_SIZE_DEF = 64;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SPAN  = 4'b0010,
    ST_ORDER = 4'b0100,
    ST_RUN   = 4'b1000
  } lr_state_t;

  typedef struct packed {
    logic load;
    logic span;
    logic order;
    logic advance;
  } lr_cmd_t;

  typedef struct packed {
    logic last;
  } lr_status_t;

  function automatic coord_t clamp_coord(coord_t v, coord_t lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic coord_t abs_diff(coord_t a, coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

endpackage

// ===== design/lr_if.sv =====
// Line command and pixel channel interfaces.
interface lr_cmd_if;
  logic           valid;
  logic           ready;
  lr_pkg::coord_t x_start;
  lr_pkg::coord_t y_start;
  lr_pkg::coord_t x_end;
  lr_pkg::coord_t y_end;
  lr_pkg::color_t line_color;

  modport source (output valid, x_start, y_start, x_end, y_end, line_color, input ready);
  modport sink (input valid, x_start, y_start, x_end, y_end, line_color, output ready);
endinterface

interface lr_pix_if;
  logic           valid;
  logic           ready;
  lr_pkg::coord_t pixel_x;
  lr_pkg::coord_t pixel_y;
  lr_pkg::color_t pixel_color;
  logic           last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== design/line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer.
//
//   channel   dir  transaction
//   in_cmd    in   one line command: two endpoints and a color
//   out_pix   out  one pixel of the line, last_pixel set on the final one
//
// A line of N pixels (N = major span + 1, at most 64) passes the setup states SPAN
// and ORDER after the command, then one pixel per cycle while out_pix is ready.
// The next command is taken in the cycle the last pixel is transferred.
// A stalled pixel holds and stops the stepping unit; reset is synchronous.
module line_rasterizer #(
  parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  lr_cmd_if.sink   in_cmd,
  lr_pix_if.source out_pix
);

  lr_pkg::lr_cmd_t    cmd;
  lr_pkg::lr_status_t status;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_ready  (in_cmd.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lr_dp #(
    .TILE_SIZE (TILE_SIZE)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .x_start     (in_cmd.x_start),
    .y_start     (in_cmd.y_start),
    .x_end       (in_cmd.x_end),
    .y_end       (in_cmd.y_end),
    .line_color  (in_cmd.line_color),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_color (out_pix.pixel_color),
    .status      (status)
  );

  assign out_pix.last_pixel = status.last;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && !out_pix.last_pixel |-> !in_cmd.ready)
    else $error("command taken while a line is still drawing");

  a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_cmd.valid && in_cmd.ready |=> !out_pix.valid)
    else $error("pixel shown during setup");

  a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && out_pix.ready && !out_pix.last_pixel
      |=> out_pix.valid && $stable(out_pix.pixel_color))
    else $error("line ended before its last pixel");

endmodule

// ===== design/lr_ctrl.sv =====
// Sequencing state machine for the line rasterizer.
module lr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lr_pkg::lr_status_t status,
  output lr_pkg::lr_cmd_t    cmd
);

  lr_pkg::lr_state_t state_r, state_nxt;
  logic accept;
  logic done;

  assign out_valid = (state_r == lr_pkg::ST_RUN);
  assign done      = out_valid && out_ready && status.last;
  assign in_ready  = (state_r == lr_pkg::ST_IDLE) || done;
  assign accept    = in_valid && in_ready;

  assign cmd.load    = accept;
  assign cmd.span    = (state_r == lr_pkg::ST_SPAN);
  assign cmd.order   = (state_r == lr_pkg::ST_ORDER);
  assign cmd.advance = out_valid && out_ready && !status.last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lr_pkg::ST_IDLE: begin
        if (accept) state_nxt = lr_pkg::ST_SPAN;
      end
      lr_pkg::ST_SPAN: begin
        state_nxt = lr_pkg::ST_ORDER;
      end
      lr_pkg::ST_ORDER: begin
        state_nxt = lr_pkg::ST_RUN;
      end
      lr_pkg::ST_RUN: begin
        if (done) state_nxt = accept ? lr_pkg::ST_SPAN : lr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lr_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/lr_dp.sv =====
// Endpoint setup and Bresenham stepping datapath.
module lr_dp #(
  parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
  input  logic               clk,
  input  lr_pkg::lr_cmd_t    cmd,
  input  lr_pkg::coord_t     x_start,
  input  lr_pkg::coord_t     y_start,
  input  lr_pkg::coord_t     x_end,
  input  lr_pkg::coord_t     y_end,
  input  lr_pkg::color_t     line_color,
  output lr_pkg::coord_t     pixel_x,
  output lr_pkg::coord_t     pixel_y,
  output lr_pkg::color_t     pixel_color,
  output lr_pkg::lr_status_t status
);

  localparam lr_pkg::coord_t Lim = lr_pkg::coord_t'(TILE_SIZE - 1);

  lr_pkg::coord_t ax_r, ay_r, bx_r, by_r;
  lr_pkg::color_t color_r;
  logic           steep_r;
  lr_pkg::coord_t maj0_r, min0_r, maj1_r, min1_r;
  lr_pkg::coord_t m_r, n_r, mend_r, dmaj_r, dmin_r;
  logic           step_neg_r;
  lr_pkg::err_t   err_r;

  lr_pkg::coord_t dx, dy;
  logic           steep;
  logic           swap;
  lr_pkg::coord_t mstart, mend, nstart, nend;
  lr_pkg::err_t   err_dec;

  assign dx    = lr_pkg::abs_diff(bx_r, ax_r);
  assign dy    = lr_pkg::abs_diff(by_r, ay_r);
  assign steep = dy > dx;

  assign swap   = maj0_r > maj1_r;
  assign mstart = swap ? maj1_r : maj0_r;
  assign mend   = swap ? maj0_r : maj1_r;
  assign nstart = swap ? min1_r : min0_r;
  assign nend   = swap ? min0_r : min1_r;

  assign err_dec = err_r - lr_pkg::err_t'({2'b00, dmin_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= lr_pkg::clamp_coord(x_start, Lim);
      ay_r    <= lr_pkg::clamp_coord(y_start, Lim);
      bx_r    <= lr_pkg::clamp_coord(x_end, Lim);
      by_r    <= lr_pkg::clamp_coord(y_end, Lim);
      color_r <= line_color;
    end
    if (cmd.span) begin
      steep_r <= steep;
      maj0_r  <= steep ? ay_r : ax_r;
      min0_r  <= steep ? ax_r : ay_r;
      maj1_r  <= steep ? by_r : bx_r;
      min1_r  <= steep ? bx_r : by_r;
    end
    if (cmd.order) begin
      m_r        <= mstart;
      n_r        <= nstart;
      mend_r     <= mend;
      dmaj_r     <= lr_pkg::coord_t'(mend - mstart);
      dmin_r     <= lr_pkg::abs_diff(nend, nstart);
      step_neg_r <= nstart > nend;
      err_r      <= lr_pkg::err_t'({2'b00, 1'b0, lr_pkg::coord_t'(mend - mstart) >> 1});
    end
    if (cmd.advance) begin
      m_r <= m_r + lr_pkg::coord_t'(1);
      if (err_dec < 0) begin
        n_r   <= step_neg_r ? n_r - lr_pkg::coord_t'(1) : n_r + lr_pkg::coord_t'(1);
        err_r <= err_dec + lr_pkg::err_t'({2'b00, dmaj_r});
      end else begin
        err_r <= err_dec;
      end
    end
  end

  assign pixel_x     = steep_r ? n_r : m_r;
  assign pixel_y     = steep_r ? m_r : n_r;
  assign pixel_color = color_r;
  assign status.last = (m_r == mend_r);

endmodule
